// ----- rtl/pump_hysteresis_controller_assert.svh -----
// assertion macros used by the controller file
`ifndef PUMP_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define PUMP_HYSTERESIS_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PHC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("phc: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PHC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("phc: next-cycle check failed");

`endif

// ----- rtl/phc_pkg.sv -----
package phc_pkg;

    // item codes
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SAMPLE    = 3'd1,
        OP_PUMP_ON   = 3'd2,
        OP_PUMP_OFF  = 3'd3,
        OP_VALVE_ON  = 3'd4,
        OP_VALVE_OFF = 3'd5,
        OP_AUTO      = 3'd6,
        OP_MANUAL    = 3'd7
    } op_t;

    // register indexes on the configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_CYCLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RUN      = 3'd3;

    // register reset values
    localparam logic [6:0]  ON_THRESHOLD_RST = 7'd30;
    localparam logic [5:0]  HYSTERESIS_RST   = 6'd10;
    localparam logic [16:0] MIN_CYCLE_RST    = 17'd600;
    localparam logic [16:0] MAX_RUN_RST      = 17'd1800;

    typedef struct packed {
        op_t        op;
        logic [6:0] moisture;
        logic       moisture_valid;
        logic       tank_high;
    } in_item_t;

    typedef struct packed {
        logic pump_on;
        logic valve_on;
        logic auto_mode;
        logic safety_stop;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  on_threshold;
        logic [5:0]  hysteresis;
        logic [16:0] min_cycle_seconds;
        logic [16:0] max_run_seconds;
    } cfg_t;

    // single-bit controller state
    typedef struct packed {
        logic pump_running;
        logic valve_open;
        logic in_auto;
        logic stopped_before;
    } flags_t;

endpackage

// ----- rtl/phc_step.sv -----
module phc_step #(
    parameter int TIME_BITS = 17
) (
    input  phc_pkg::in_item_t  item,
    input  phc_pkg::cfg_t      cfg,
    input  phc_pkg::flags_t    flags,
    input  logic [TIME_BITS-1:0] run_time,
    input  logic [TIME_BITS-1:0] off_time,
    output phc_pkg::flags_t    flags_next,
    output logic [TIME_BITS-1:0] run_time_next,
    output logic [TIME_BITS-1:0] off_time_next,
    output phc_pkg::out_item_t result
);

    localparam int CMP_W = (TIME_BITS > 17) ? TIME_BITS : 17;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [7:0] stop_level;
    logic       rest_done;
    logic       safety;

    // stop level in one extra bit so it never wraps
    assign stop_level = {1'b0, cfg.on_threshold} + {2'b00, cfg.hysteresis};
    assign rest_done  = !flags.stopped_before ||
                        (CMP_W'(off_time) >= CMP_W'(cfg.min_cycle_seconds));

    // next state for one item
    always_comb
    begin
        flags_next    = flags;
        run_time_next = run_time;
        off_time_next = off_time;
        safety        = 1'b0;
        case (item.op)
            phc_pkg::OP_TICK:
            begin
                if (flags.pump_running)
                begin
                    if (run_time != TIME_MAX)
                        run_time_next = run_time + 1'b1;
                end
                else if (off_time != TIME_MAX)
                begin
                    off_time_next = off_time + 1'b1;
                end
            end
            phc_pkg::OP_SAMPLE:
            begin
                // auto hysteresis rules
                if (flags.in_auto && item.moisture_valid)
                begin
                    if (!flags.pump_running)
                    begin
                        if (item.moisture < cfg.on_threshold && !item.tank_high && rest_done)
                        begin
                            flags_next.valve_open   = 1'b1;
                            flags_next.pump_running = 1'b1;
                            run_time_next           = '0;
                        end
                    end
                    else if ({1'b0, item.moisture} >= stop_level || item.tank_high)
                    begin
                        flags_next.pump_running   = 1'b0;
                        flags_next.valve_open     = 1'b0;
                        flags_next.stopped_before = 1'b1;
                        off_time_next             = '0;
                    end
                end
                // safety run timer, in either mode
                if (flags_next.pump_running &&
                    CMP_W'(run_time_next) >= CMP_W'(cfg.max_run_seconds))
                begin
                    flags_next.pump_running   = 1'b0;
                    flags_next.valve_open     = 1'b0;
                    flags_next.stopped_before = 1'b1;
                    off_time_next             = '0;
                    safety                    = 1'b1;
                end
            end
            phc_pkg::OP_PUMP_ON:
            begin
                flags_next.in_auto = 1'b0;
                if (!flags.pump_running)
                begin
                    flags_next.pump_running = 1'b1;
                    run_time_next           = '0;
                end
            end
            phc_pkg::OP_PUMP_OFF:
            begin
                if (flags.pump_running)
                begin
                    flags_next.pump_running   = 1'b0;
                    flags_next.stopped_before = 1'b1;
                    off_time_next             = '0;
                end
            end
            phc_pkg::OP_VALVE_ON:
            begin
                flags_next.in_auto    = 1'b0;
                flags_next.valve_open = 1'b1;
            end
            phc_pkg::OP_VALVE_OFF:
            begin
                flags_next.valve_open = 1'b0;
            end
            phc_pkg::OP_AUTO:
            begin
                flags_next.in_auto = 1'b1;
            end
            default:
            begin
                flags_next.in_auto = 1'b0;
            end
        endcase
    end

    assign result.pump_on     = flags_next.pump_running;
    assign result.valve_on    = flags_next.valve_open;
    assign result.auto_mode   = flags_next.in_auto;
    assign result.safety_stop = safety;

endmodule

// ----- rtl/pump_hysteresis_controller.sv -----
// Irrigation pump and valve controller with hysteresis and a safety run timer.
// Input channel: in_valid / in_stall / in_item carry one beat per tick, sensor
// sample or command; a beat is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall / out_item return one result beat per
// input beat, in order, taken when out_valid is high and out_stall is low.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data write the four
// registers (threshold, hysteresis, minimum off time, maximum run time);
// cfg_ready is always high, indexes past the last register are ignored.
// Write configuration only while no beat is in flight.
// Pipeline: a taken beat lands in the input register, its result is computed
// by one pass of compare and counter logic and registered in the output
// register, which then drives out_valid high.
// Throughput: one beat per cycle while the receiver does not stall.
// Stall: when the receiver stalls with a full output register, the input
// register holds its beat and in_stall rises in the same cycle.
// Reset: pump and valve off, auto mode, counters cleared, registers at defaults.
`include "pump_hysteresis_controller_assert.svh"

module pump_hysteresis_controller #(
    parameter int TIME_BITS = 17
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  phc_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output phc_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [phc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [phc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    phc_pkg::in_item_t    s1_item_reg;
    logic                 s1_valid_reg;
    logic                 out_valid_reg;
    phc_pkg::out_item_t   out_item_reg;
    phc_pkg::cfg_t        cfg_reg;
    phc_pkg::flags_t      flags_reg;
    phc_pkg::flags_t      flags_next;
    logic [TIME_BITS-1:0] run_time_reg;
    logic [TIME_BITS-1:0] run_time_next;
    logic [TIME_BITS-1:0] off_time_reg;
    logic [TIME_BITS-1:0] off_time_next;
    phc_pkg::out_item_t   step_result;
    logic                 out_free;
    logic                 s1_adv;
    logic                 s1_free;

    // pipeline flow control
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || out_free;
    assign in_stall  = !s1_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold      <= phc_pkg::ON_THRESHOLD_RST;
            cfg_reg.hysteresis        <= phc_pkg::HYSTERESIS_RST;
            cfg_reg.min_cycle_seconds <= phc_pkg::MIN_CYCLE_RST;
            cfg_reg.max_run_seconds   <= phc_pkg::MAX_RUN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                phc_pkg::REG_ON_THRESHOLD: cfg_reg.on_threshold      <= cfg_data[6:0];
                phc_pkg::REG_HYSTERESIS:   cfg_reg.hysteresis        <= cfg_data[5:0];
                phc_pkg::REG_MIN_CYCLE:    cfg_reg.min_cycle_seconds <= cfg_data[16:0];
                phc_pkg::REG_MAX_RUN:      cfg_reg.max_run_seconds   <= cfg_data[16:0];
                default:                   cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
            s1_item_reg <= in_item;
    end

    // per-item state update
    phc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .item          (s1_item_reg),
        .cfg           (cfg_reg),
        .flags         (flags_reg),
        .run_time      (run_time_reg),
        .off_time      (off_time_reg),
        .flags_next    (flags_next),
        .run_time_next (run_time_next),
        .off_time_next (off_time_next),
        .result        (step_result)
    );

    // controller state, advanced once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.pump_running   <= 1'b0;
            flags_reg.valve_open     <= 1'b0;
            flags_reg.in_auto        <= 1'b1;
            flags_reg.stopped_before <= 1'b0;
            run_time_reg             <= '0;
            off_time_reg             <= '0;
        end
        else if (s1_adv)
        begin
            flags_reg    <= flags_next;
            run_time_reg <= run_time_next;
            off_time_reg <= off_time_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_item_reg <= step_result;
    end

    // checks on the block's own logic
    `PHC_ASSERT_IMP(a_safety_relays_off, clk, rst_n,
        out_valid_reg && out_item_reg.safety_stop,
        !out_item_reg.pump_on && !out_item_reg.valve_on)
    `PHC_ASSERT_IMP(a_safety_only_on_sample, clk, rst_n,
        s1_adv && step_result.safety_stop,
        s1_item_reg.op == phc_pkg::OP_SAMPLE)
    `PHC_ASSERT_NEXT(a_held_beat_stays, clk, rst_n,
        s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_item_reg))
    `PHC_ASSERT_NEXT(a_manual_pump_on, clk, rst_n,
        s1_adv && s1_item_reg.op == phc_pkg::OP_PUMP_ON,
        flags_reg.pump_running && !flags_reg.in_auto)

endmodule

// ----- test/tb_pump_hysteresis_controller.sv -----
`timescale 1ns / 1ps

module tb_pump_hysteresis_controller;

    localparam int TIME_BITS   = 17;
    localparam int LONG_HOLD   = 300;
    localparam int CFG_INDEX_W = phc_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = phc_pkg::CFG_DATA_W;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_TOGGLE,
        STALL_HEAVY
    } stall_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    phc_pkg::in_item_t      in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    phc_pkg::out_item_t     out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    pump_hysteresis_controller #(
        .TIME_BITS(TIME_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // beats waiting to be sent and relay status waiting to come back
    phc_pkg::in_item_t  pending_beats[$];
    phc_pkg::out_item_t expected_status[$];
    int                 mismatch_count = 0;

    // handshake flags seen at the last rising edge
    bit beat_taken = 1'b0;
    bit cfg_done = 1'b0;

    // sender and receiver pacing
    int           burst_left = 0;
    int           gap_left = 0;
    int           holds_asked = 0;
    int           holds_granted = 0;
    int           hold_left = 0;
    int           segment_left = 0;
    stall_style_t stall_style = STALL_NONE;

    // controller mirror
    phc_pkg::cfg_t        settings_shadow;
    logic                 pump_is_on;
    logic                 valve_is_open;
    logic                 auto_enabled;
    logic                 has_stopped;
    logic [TIME_BITS-1:0] run_secs;
    logic [TIME_BITS-1:0] off_secs;

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // pump transitions clear the counter of the new phase
    task automatic drive_pump(input logic turn_on);
        if (turn_on != pump_is_on)
        begin
            pump_is_on = turn_on;
            if (turn_on)
            begin
                run_secs = '0;
            end
            else
            begin
                off_secs = '0;
                has_stopped = 1'b1;
            end
        end
    endtask

    // relay status after one beat
    task automatic compute_relay_status(input phc_pkg::in_item_t beat,
                                        output phc_pkg::out_item_t status);
        logic [7:0] stop_level;
        logic       tripped;
        stop_level = {1'b0, settings_shadow.on_threshold} + {2'b00, settings_shadow.hysteresis};
        tripped = 1'b0;
        case (beat.op)
            phc_pkg::OP_TICK:
            begin
                if (pump_is_on)
                begin
                    if (run_secs != {TIME_BITS{1'b1}})
                        run_secs = run_secs + 1'b1;
                end
                else if (off_secs != {TIME_BITS{1'b1}})
                begin
                    off_secs = off_secs + 1'b1;
                end
            end
            phc_pkg::OP_SAMPLE:
            begin
                // hysteresis rules only act on valid readings in auto mode
                if (auto_enabled && beat.moisture_valid)
                begin
                    if (!pump_is_on)
                    begin
                        if (beat.moisture < settings_shadow.on_threshold && !beat.tank_high &&
                            (!has_stopped || off_secs >= settings_shadow.min_cycle_seconds))
                        begin
                            valve_is_open = 1'b1;
                            drive_pump(1'b1);
                        end
                    end
                    else if ({1'b0, beat.moisture} >= stop_level || beat.tank_high)
                    begin
                        drive_pump(1'b0);
                        valve_is_open = 1'b0;
                    end
                end
                // run timer trips in either mode
                if (pump_is_on && run_secs >= settings_shadow.max_run_seconds)
                begin
                    drive_pump(1'b0);
                    valve_is_open = 1'b0;
                    tripped = 1'b1;
                end
            end
            phc_pkg::OP_PUMP_ON:
            begin
                auto_enabled = 1'b0;
                drive_pump(1'b1);
            end
            phc_pkg::OP_PUMP_OFF:
            begin
                drive_pump(1'b0);
            end
            phc_pkg::OP_VALVE_ON:
            begin
                auto_enabled = 1'b0;
                valve_is_open = 1'b1;
            end
            phc_pkg::OP_VALVE_OFF:
            begin
                valve_is_open = 1'b0;
            end
            phc_pkg::OP_AUTO:
            begin
                auto_enabled = 1'b1;
            end
            default:
            begin
                auto_enabled = 1'b0;
            end
        endcase
        status.pump_on = pump_is_on;
        status.valve_on = valve_is_open;
        status.auto_mode = auto_enabled;
        status.safety_stop = tripped;
    endtask

    function automatic void check_field(string field, logic due_bit, logic got_bit);
        if (due_bit !== got_bit)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, due_bit,
                     got_bit);
            mismatch_count++;
        end
    endfunction

    function automatic phc_pkg::in_item_t make_beat(phc_pkg::op_t op, logic [6:0] moisture,
                                                    logic valid, logic full);
        phc_pkg::in_item_t beat;
        beat.op = op;
        beat.moisture = moisture;
        beat.moisture_valid = valid;
        beat.tank_high = full;
        return beat;
    endfunction

    // random beat, moisture mostly close to the switching levels
    function automatic phc_pkg::in_item_t random_beat();
        int           pick;
        int           lo;
        int           hi;
        phc_pkg::op_t op;
        logic [6:0]   moisture;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = phc_pkg::OP_TICK;
        else if (pick < 70)
            op = phc_pkg::OP_SAMPLE;
        else if (pick < 78)
            op = phc_pkg::OP_AUTO;
        else
            op = phc_pkg::op_t'($urandom_range(2, 7));
        lo = int'(settings_shadow.on_threshold) - 3;
        hi = int'(settings_shadow.on_threshold) + int'(settings_shadow.hysteresis) + 3;
        if (lo < 0)
            lo = 0;
        if (hi > 127)
            hi = 127;
        if ($urandom_range(0, 1) == 0)
            moisture = 7'($urandom_range(lo, hi));
        else
            moisture = 7'($urandom_range(0, 127));
        return make_beat(op, moisture, $urandom_range(0, 6) != 0, $urandom_range(0, 6) == 0);
    endfunction

    // monitor: mirror config writes, predict accepted beats, check results
    always @(posedge clk)
    begin
        phc_pkg::out_item_t due;
        if (!rst_n)
        begin
            beat_taken = 1'b0;
            cfg_done = 1'b0;
            settings_shadow.on_threshold = phc_pkg::ON_THRESHOLD_RST;
            settings_shadow.hysteresis = phc_pkg::HYSTERESIS_RST;
            settings_shadow.min_cycle_seconds = phc_pkg::MIN_CYCLE_RST;
            settings_shadow.max_run_seconds = phc_pkg::MAX_RUN_RST;
            pump_is_on = 1'b0;
            valve_is_open = 1'b0;
            auto_enabled = 1'b1;
            has_stopped = 1'b0;
            run_secs = '0;
            off_secs = '0;
        end
        else
        begin
            cfg_done = cfg_valid && cfg_ready;
            if (cfg_done)
            begin
                case (cfg_index)
                    phc_pkg::REG_ON_THRESHOLD: settings_shadow.on_threshold = cfg_data[6:0];
                    phc_pkg::REG_HYSTERESIS:   settings_shadow.hysteresis = cfg_data[5:0];
                    phc_pkg::REG_MIN_CYCLE:    settings_shadow.min_cycle_seconds = cfg_data;
                    phc_pkg::REG_MAX_RUN:      settings_shadow.max_run_seconds = cfg_data;
                    default:                   ;
                endcase
            end
            beat_taken = in_valid && !in_stall;
            if (beat_taken)
            begin
                compute_relay_status(in_item, due);
                expected_status.push_back(due);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %b", $time,
                             out_item);
                    mismatch_count++;
                end
                else
                begin
                    due = expected_status.pop_front();
                    check_field("pump_on", due.pump_on, out_item.pump_on);
                    check_field("valve_on", due.valve_on, out_item.valve_on);
                    check_field("auto_mode", due.auto_mode, out_item.auto_mode);
                    check_field("safety_stop", due.safety_stop, out_item.safety_stop);
                end
            end
        end
    end

    // driver: bursts of beats with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || beat_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                in_item <= pending_beats.pop_front();
                in_valid <= 1'b1;
                if (burst_left != 0)
                begin
                    burst_left = burst_left - 1;
                end
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall styles in segments, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (holds_granted != holds_asked)
            begin
                holds_granted++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (segment_left == 0)
                begin
                    stall_style = stall_style_t'($urandom_range(0, 3));
                    segment_left = $urandom_range(10, 60);
                end
                else
                begin
                    segment_left--;
                end
                case (stall_style)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 2) == 0);
                    STALL_TOGGLE: out_stall <= ~out_stall;
                    default:      out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // wait until every beat is sent and answered, then let the pipeline settle
    task automatic drain_controller();
        while (pending_beats.size() != 0 || in_valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!cfg_done);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input phc_pkg::cfg_t setting);
        drain_controller();
        write_register(phc_pkg::REG_ON_THRESHOLD, CFG_DATA_W'(setting.on_threshold));
        write_register(phc_pkg::REG_HYSTERESIS, CFG_DATA_W'(setting.hysteresis));
        write_register(phc_pkg::REG_MIN_CYCLE, setting.min_cycle_seconds);
        write_register(phc_pkg::REG_MAX_RUN, setting.max_run_seconds);
    endtask

    // stimulus
    initial
    begin
        phc_pkg::cfg_t phase_settings[6];
        phase_settings[0] = '{7'd30, 6'd10, 17'd3, 17'd8};
        phase_settings[1] = '{7'd0, 6'd0, 17'd0, 17'd0};
        phase_settings[2] = '{7'd127, 6'd63, 17'h1FFFF, 17'h1FFFF};
        phase_settings[3] = '{7'd100, 6'd50, 17'd2, 17'd5};
        for (int i = 4; i < 6; i++)
        begin
            phase_settings[i].on_threshold = 7'($urandom_range(0, 127));
            phase_settings[i].hysteresis = 6'($urandom_range(0, 63));
            phase_settings[i].min_cycle_seconds = 17'($urandom_range(0, 6));
            phase_settings[i].max_run_seconds = 17'($urandom_range(0, 12));
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats at reset settings
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd29, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_TICK, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd39, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd127, 1'b0, 1'b1));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd40, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_TICK, 7'd127, 1'b1, 1'b1));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd0, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_VALVE_ON, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_PUMP_ON, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_PUMP_ON, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_PUMP_OFF, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_PUMP_OFF, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_VALVE_OFF, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd0, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_AUTO, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd0, 1'b1, 1'b1));
        pending_beats.push_back(make_beat(phc_pkg::OP_MANUAL, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_TICK, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_AUTO, 7'd0, 1'b0, 1'b0));

        // zero maximum: auto start and safety stop in one sample, manual trip too
        apply_settings('{7'd20, 6'd0, 17'd0, 17'd0});
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd19, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd20, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_PUMP_ON, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_TICK, 7'd0, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(phc_pkg::OP_SAMPLE, 7'd50, 1'b0, 1'b0));

        // random phases, each after an idle settings change
        for (int p = 0; p < 6; p++)
        begin
            apply_settings(phase_settings[p]);
            if (p == 0)
            begin
                // writes past the last register are ignored
                write_register(CFG_INDEX_W'(7), {CFG_DATA_W{1'b1}});
                write_register(CFG_INDEX_W'(4), '0);
            end
            if (p == 1)
                holds_asked++;
            for (int n = 0; n < 85; n++)
                pending_beats.push_back(random_beat());
        end

        drain_controller();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
